// ===== rtl/core/linear_interp_resampler_top_macros.svh =====
// assertion macros for the linear interpolation resampler
// no dependencies; included by the files that carry assertions
`ifndef LINEAR_INTERP_RESAMPLER_TOP_MACROS_SVH
`define LINEAR_INTERP_RESAMPLER_TOP_MACROS_SVH
`ifndef SYNTHESIS
// property checked on every clock edge outside reset
`define LIR_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// property checked on every clock edge, reset included
`define LIR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LIR_ASSERT(lbl, clk, rst_n, prop, msg)
`define LIR_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ===== rtl/core/lir_pkg.sv =====
// shared constants and types of the linear interpolation resampler
// no dependencies; used by the interfaces and all modules
package lir_pkg;

  // fixed field widths
  localparam int SAMPLE_W = 8;
  localparam int CFG_W = 19;

  // default number of fraction bits of the phase step
  localparam int FRAC_BITS_DEF = 16;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_MUL,
    ST_EMIT,
    ST_FINISH
  } lir_state_t;

endpackage

// ===== rtl/core/lir_stream_if.sv =====
// valid/ready stream interfaces for input and result words
// depends on lir_pkg
interface lir_in_if;
  import lir_pkg::*;

  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink (input valid, input sample_in, output ready);
endinterface

interface lir_out_if;
  import lir_pkg::*;

  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample_out;
  logic                run_last;

  modport source (output valid, output sample_out, output run_last, input ready);
  modport sink (input valid, input sample_out, input run_last, output ready);
endinterface

// ===== rtl/core/lir_interp_unit.sv =====
// shared interpolation unit: one multiply per output, product registered,
// then floor shift and add of the left neighbour; depends on lir_pkg
module lir_interp_unit #(
  parameter int FRAC_BITS = lir_pkg::FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         mul_en,
  input  logic [FRAC_BITS-1:0]         frac,
  input  logic [lir_pkg::SAMPLE_W-1:0] held,
  input  logic [lir_pkg::SAMPLE_W-1:0] next,
  output logic [lir_pkg::SAMPLE_W-1:0] result
);
  import lir_pkg::*;

  localparam int DIFF_W = SAMPLE_W + 1;
  localparam int PROD_W = FRAC_BITS + 1 + DIFF_W;
  localparam int Q_W = DIFF_W + 1;

  logic signed [FRAC_BITS:0]  frac_s;
  logic signed [DIFF_W-1:0]   diff;
  logic signed [PROD_W-1:0]   prod_nxt;
  logic signed [PROD_W-1:0]   prod_r;
  logic signed [Q_W-1:0]      q;
  logic signed [Q_W-1:0]      sum;

  // slope times fraction
  assign frac_s = $signed({1'b0, frac});
  assign diff = $signed({1'b0, next}) - $signed({1'b0, held});
  assign prod_nxt = frac_s * diff;

  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod_r <= prod_nxt;
    end
  end

  // arithmetic shift floors toward minus infinity; sum stays between neighbours
  assign q = prod_r[PROD_W-1:FRAC_BITS];
  assign sum = $signed({2'b00, held}) + q;
  assign result = sum[SAMPLE_W-1:0];

endmodule

// ===== rtl/core/lir_seq.sv =====
// sequencer of the resampler: phase accumulator, held sample, output register
// depends on lir_pkg, lir_stream_if and the assertion macro header
`include "linear_interp_resampler_top_macros.svh"

module lir_seq #(
  parameter int FRAC_BITS = lir_pkg::FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  lir_in_if.sink                       in_ch,
  lir_out_if.source                    out_ch,
  input  logic [FRAC_BITS+2:0]         step,
  output logic                         mul_en,
  output logic [FRAC_BITS-1:0]         frac,
  output logic [lir_pkg::SAMPLE_W-1:0] held,
  output logic [lir_pkg::SAMPLE_W-1:0] next,
  input  logic [lir_pkg::SAMPLE_W-1:0] result
);
  import lir_pkg::*;

  localparam int POS_W = FRAC_BITS + 3;
  localparam logic [POS_W-1:0] ONE_C = POS_W'(1) << FRAC_BITS;
  localparam logic [POS_W-1:0] POS_CAP = POS_W'(1) << (FRAC_BITS + 2);

  lir_state_t          state_r, state_nxt;
  logic [SAMPLE_W-1:0] next_r, next_nxt;
  logic [SAMPLE_W-1:0] held_r, held_nxt;
  logic                have_r, have_nxt;
  logic [POS_W-1:0]    pos_r, pos_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [SAMPLE_W-1:0] out_data_r, out_data_nxt;
  logic                out_last_r, out_last_nxt;
  logic                slot_free;
  logic [POS_W-1:0]    pos_sum;
  logic                run_end;

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      held_r      <= '0;
      have_r      <= 1'b0;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      held_r      <= held_nxt;
      have_r      <= have_nxt;
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    next_r     <= next_nxt;
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
  end

  // next output position and end of run
  assign slot_free = !out_valid_r || out_ch.ready;
  assign pos_sum = pos_r + step;
  assign run_end = (pos_sum >= ONE_C);

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    next_nxt      = next_r;
    held_nxt      = held_r;
    have_nxt      = have_r;
    pos_nxt       = pos_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    mul_en        = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          next_nxt  = in_ch.sample_in;
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (!have_r) begin
          state_nxt = ST_EMIT;
        end else if (pos_r >= ONE_C) begin
          state_nxt = ST_FINISH;
        end else begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        mul_en    = 1'b1;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          if (!have_r) begin
            // first sample passes straight through
            out_data_nxt = next_r;
            out_last_nxt = 1'b1;
            have_nxt     = 1'b1;
            held_nxt     = next_r;
            pos_nxt      = step;
            state_nxt    = ST_IDLE;
          end else begin
            out_data_nxt = result;
            out_last_nxt = run_end;
            pos_nxt      = pos_sum;
            state_nxt    = run_end ? ST_FINISH : ST_MUL;
          end
        end
      end
      ST_FINISH: begin
        pos_nxt   = pos_r - ONE_C;
        held_nxt  = next_r;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // ports
  assign in_ch.ready       = (state_r == ST_IDLE);
  assign out_ch.valid      = out_valid_r;
  assign out_ch.sample_out = out_data_r;
  assign out_ch.run_last   = out_last_r;
  assign frac              = pos_r[FRAC_BITS-1:0];
  assign held              = held_r;
  assign next              = next_r;

  // checks
  `LIR_ASSERT(a_pos_bound, clk, rst_n, (state_r == ST_IDLE) |-> (pos_r <= POS_CAP), "phase position out of range")
  `LIR_ASSERT(a_finish_pos, clk, rst_n, (state_r == ST_FINISH) |-> (pos_r >= ONE_C), "run finished below one")
  `LIR_ASSERT(a_last_ends, clk, rst_n, (state_r == ST_EMIT && slot_free && out_last_nxt) |=> (state_r == ST_FINISH || state_r == ST_IDLE), "run goes on after last word")
  `LIR_ASSERT(a_have_keeps, clk, rst_n, have_r |=> have_r, "first sample flag dropped")

endmodule

// ===== rtl/core/linear_interp_resampler_top.sv =====
// top level of the linear interpolation resampler: step register and clamp
// depends on lir_pkg, lir_stream_if, lir_seq and lir_interp_unit

// Resamples unsigned 8-bit audio by linear interpolation. Write the output
// spacing (unsigned, FRAC_BITS fraction bits, reset 1.0) through cfg_we and
// cfg_wdata while the block is idle; it is clamped to the range 1/64 .. 4.0.
// The first input word is passed through as one result; every later word
// yields every output position between the held sample and itself, the last
// of them marked by run_last, and may yield none when stepping down. One
// shared multiplier computes the outputs one at a time, and the result side
// may stall it. A new word is taken only once the previous one is done.
module linear_interp_resampler_top #(
  parameter int FRAC_BITS = lir_pkg::FRAC_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  lir_in_if.sink                    in_ch,
  lir_out_if.source                 out_ch,
  input  logic                      cfg_we,
  input  logic [lir_pkg::CFG_W-1:0] cfg_wdata
);
  import lir_pkg::*;

  localparam int POS_W = FRAC_BITS + 3;
  localparam int CMP_W = (CFG_W > POS_W) ? CFG_W : POS_W;
  localparam logic [CMP_W-1:0] STEP_RST = CMP_W'(1) << FRAC_BITS;
  localparam logic [CMP_W-1:0] STEP_MIN = CMP_W'(1) << (FRAC_BITS - 6);
  localparam logic [CMP_W-1:0] STEP_MAX = CMP_W'(1) << (FRAC_BITS + 2);

  logic [CMP_W-1:0]    step_cfg_r;
  logic [CMP_W-1:0]    step_clamped;
  logic [POS_W-1:0]    step;
  logic                mul_en;
  logic [FRAC_BITS-1:0] frac;
  logic [SAMPLE_W-1:0] held;
  logic [SAMPLE_W-1:0] next;
  logic [SAMPLE_W-1:0] result;

  // phase step register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_cfg_r <= STEP_RST;
    end else if (cfg_we) begin
      step_cfg_r <= CMP_W'(cfg_wdata);
    end
  end

  // clamp to the supported step range
  always_comb begin
    if (step_cfg_r < STEP_MIN) begin
      step_clamped = STEP_MIN;
    end else if (step_cfg_r > STEP_MAX) begin
      step_clamped = STEP_MAX;
    end else begin
      step_clamped = step_cfg_r;
    end
  end
  assign step = step_clamped[POS_W-1:0];

  lir_seq #(
    .FRAC_BITS(FRAC_BITS)
  ) u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .step   (step),
    .mul_en (mul_en),
    .frac   (frac),
    .held   (held),
    .next   (next),
    .result (result)
  );

  lir_interp_unit #(
    .FRAC_BITS(FRAC_BITS)
  ) u_interp (
    .clk    (clk),
    .mul_en (mul_en),
    .frac   (frac),
    .held   (held),
    .next   (next),
    .result (result)
  );

endmodule

// ===== test/lir_resample_sb_pkg.sv =====
// scoreboard for the linear interpolation resampler test: predicts result words
// from accepted sample words and the phase step; depends on lir_pkg
package lir_resample_sb_pkg;
  import lir_pkg::*;

  // fixed point limits of the phase step at the default fraction width
  localparam int unsigned STEP_ONE = 1 << FRAC_BITS_DEF;
  localparam int unsigned STEP_LO  = STEP_ONE >> 6;
  localparam int unsigned STEP_HI  = STEP_ONE << 2;
  localparam int          RUN_MAX  = 64;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                last;
  } result_word_t;

  class resample_scoreboard;
    logic [CFG_W-1:0]    step_reg;
    logic [SAMPLE_W-1:0] held;
    bit                  primed;
    int unsigned         pos;
    result_word_t        due_q[$];
    int                  errors;
    int                  words_in;
    int                  words_out;
    int                  empty_runs;
    int                  full_runs;

    function new();
      step_reg = CFG_W'(STEP_ONE);
      held = '0;
      primed = 1'b0;
      pos = 0;
      errors = 0;
      words_in = 0;
      words_out = 0;
      empty_runs = 0;
      full_runs = 0;
    endfunction

    function void set_step(logic [CFG_W-1:0] v);
      step_reg = v;
    endfunction

    function int pending();
      return due_q.size();
    endfunction

    // step as the block uses it, clamped to 1/64 .. 4.0
    function int unsigned clamped_step();
      int unsigned s;
      s = step_reg;
      if (s < STEP_LO) s = STEP_LO;
      if (s > STEP_HI) s = STEP_HI;
      return s;
    endfunction

    // left + floor(frac * (right - left)), arithmetic shift floors negatives
    function logic [SAMPLE_W-1:0] lerp(logic [SAMPLE_W-1:0] left,
                                       logic [SAMPLE_W-1:0] right,
                                       int unsigned frac);
      longint l;
      longint r;
      longint f;
      longint q;
      l = left;
      r = right;
      f = frac;
      q = ((f * (r - l)) >>> FRAC_BITS_DEF) + l;
      if (q < 0) q = 0;
      if (q > 255) q = 255;
      return q[SAMPLE_W-1:0];
    endfunction

    // expected run of result words for one accepted sample word
    function void note_sample(logic [SAMPLE_W-1:0] s);
      int unsigned  stp;
      int           n;
      result_word_t w;
      stp = clamped_step();
      words_in++;
      if (!primed) begin
        primed = 1'b1;
        held = s;
        pos = stp;
        w.sample = s;
        w.last = 1'b1;
        due_q = {due_q, w};
        return;
      end
      n = 0;
      while (pos < STEP_ONE && n < RUN_MAX) begin
        w.sample = lerp(held, s, pos);
        // the run ends where the next position reaches one or the run is full
        w.last = ((pos + stp) >= STEP_ONE) || (n + 1 == RUN_MAX);
        due_q = {due_q, w};
        n++;
        pos += stp;
      end
      if (n == 0) empty_runs++;
      if (n == RUN_MAX) full_runs++;
      pos = (pos >= STEP_ONE) ? pos - STEP_ONE : 0;
      held = s;
    endfunction

    // compare one accepted result word with the oldest prediction
    function void check_word(logic [SAMPLE_W-1:0] s, logic last);
      result_word_t w;
      if (due_q.size() == 0) begin
        errors++;
        $display("%0t: result word with none expected: sample_out %0d run_last %0b",
                 $time, s, last);
        return;
      end
      w = due_q.pop_front();
      words_out++;
      if (s !== w.sample) begin
        errors++;
        $display("%0t: sample_out mismatch: expected %0d, actual %0d",
                 $time, w.sample, s);
      end
      if (last !== w.last) begin
        errors++;
        $display("%0t: run_last mismatch: expected %0b, actual %0b",
                 $time, w.last, last);
      end
    endfunction
  endclass

endpackage

// ===== test/linear_interp_resampler_top_test.sv =====
// self-checking test of linear_interp_resampler_top: directed and random sample
// words over many phase steps; depends on lir_pkg, the stream interfaces and
// lir_resample_sb_pkg
module linear_interp_resampler_top_test;
  timeunit 1ns;
  timeprecision 1ps;
  import lir_pkg::*;
  import lir_resample_sb_pkg::*;

  localparam int RAND_WORDS   = 400;
  localparam int DRAIN_CYCLES = 20;
  localparam int SQUEEZE_AT   = 150;
  localparam int SQUEEZE_LEN  = 300;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             cfg_we;
  logic [CFG_W-1:0] cfg_wdata;
  bit               calm;
  int               step_writes;
  resample_scoreboard sb;

  lir_in_if  in_ch();
  lir_out_if out_ch();

  linear_interp_resampler_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // offer one sample word, with random gaps unless calm
  task automatic send_word(input logic [SAMPLE_W-1:0] s);
    if (!calm) begin
      while ($urandom_range(0, 99) < 13) begin
        in_ch.valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_ch.valid <= 1'b1;
    in_ch.sample_in <= s;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_sample(s);
  endtask

  // write the phase step once the block has drained
  task automatic write_step(input logic [CFG_W-1:0] v);
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_step(v);
    step_writes++;
  endtask

  // random step: mostly in range, sometimes clamped on either side
  function automatic logic [CFG_W-1:0] pick_step();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return CFG_W'($urandom_range(0, STEP_LO - 1));
    if (r < 14) return CFG_W'($urandom_range(STEP_HI + 1, (1 << CFG_W) - 1));
    if (r < 20) return CFG_W'(($urandom_range(0, 1) != 0) ? STEP_LO : STEP_HI);
    if (r < 60) return CFG_W'($urandom_range(STEP_LO, STEP_ONE));
    return CFG_W'($urandom_range(STEP_ONE, STEP_HI));
  endfunction

  // random sample: extremes, small moves, or anything
  function automatic logic [SAMPLE_W-1:0] pick_sample(logic [SAMPLE_W-1:0] prev);
    int r;
    int v;
    r = $urandom_range(0, 99);
    if (r < 10) return ($urandom_range(0, 1) != 0) ? 8'hff : 8'h00;
    if (r < 35) begin
      v = int'(prev) + $urandom_range(0, 16) - 8;
      if (v < 0) v = 0;
      if (v > 255) v = 255;
      return SAMPLE_W'(v);
    end
    return SAMPLE_W'($urandom_range(0, 255));
  endfunction

  // result side: random stalls, one long hold-off while words keep coming
  initial begin
    int  hold;
    bit  squeezed;
    hold = 0;
    squeezed = 1'b0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_ch.valid && out_ch.ready) sb.check_word(out_ch.sample_out, out_ch.run_last);
      if (!squeezed && sb.words_in >= SQUEEZE_AT) begin
        squeezed = 1'b1;
        hold = SQUEEZE_LEN;
      end
      if (hold > 0) begin
        hold--;
        out_ch.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 99) < 13) begin
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // stimulus
  initial begin
    int                  n_rand;
    int                  phase;
    int                  len;
    int                  drain;
    logic [SAMPLE_W-1:0] prev;
    sb = new();
    n_rand = 0;
    phase = 0;
    prev = 8'h80;
    calm = 1'b0;
    step_writes = 0;
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    in_ch.valid <= 1'b0;
    in_ch.sample_in <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset step of one: first word passes through, then extremes, flat and falls
    send_word(8'h80);
    send_word(8'h00);
    send_word(8'hff);
    send_word(8'h00);
    send_word(8'hff);
    send_word(8'hff);
    send_word(8'h25);
    // zero step runs at the minimum: 64 words per input, rising and falling
    write_step('0);
    send_word(8'h00);
    send_word(8'hff);
    send_word(8'h00);
    write_step(CFG_W'(STEP_LO - 1));
    send_word(8'hc8);
    // above 4.0: clamped, most inputs give no output
    write_step(CFG_W'(STEP_HI + 1));
    send_word(8'h0a);
    send_word(8'hfa);
    send_word(8'h03);
    send_word(8'h4d);
    send_word(8'h8c);
    write_step('1);
    send_word(8'h5a);
    send_word(8'h5b);
    // step change with a pending phase kept
    write_step(CFG_W'(STEP_ONE >> 1));
    send_word(8'hff);
    send_word(8'h01);
    write_step(CFG_W'(STEP_LO));
    send_word(8'h05);

    // random phases, one of them without any idling
    while (n_rand < RAND_WORDS) begin
      write_step(pick_step());
      calm = (phase == 3);
      len = calm ? 80 : $urandom_range(20, 50);
      repeat (len) begin
        prev = pick_sample(prev);
        send_word(prev);
        n_rand++;
      end
      phase++;
    end
    calm = 1'b0;
    in_ch.valid <= 1'b0;

    // drain, then let the block settle
    drain = 0;
    while (sb.pending() != 0 && drain < 200000) begin
      @(posedge clk);
      drain++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.pending() != 0) begin
      sb.errors++;
      $display("%0t: %0d result words never arrived", $time, sb.pending());
    end
    $display("covered %0d sample words and %0d result words over %0d step settings",
             sb.words_in, sb.words_out, step_writes);
    $display("%0d words gave no result, %0d gave a full run of 64",
             sb.empty_runs, sb.full_runs);
    if (sb.errors == 0) begin
      $display("linear_interp_resampler_top test passed");
    end else begin
      $display("linear_interp_resampler_top test failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5000000;
    $display("linear_interp_resampler_top test failed");
    $finish;
  end

endmodule
